[hw/rtl/lrupr_pkg.sv]
// shared types and constants of the lru page replacement block
package lrupr_pkg;

   // widths of the fixed item fields
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 88;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CNT_W      = 32;

   // saturation value of the hit and fault counters
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   // register index codes, taken from paddr[2]
   localparam logic REG_FRAMES_IN_USE = 1'b0;

   // configuration handed from the register port to the engine
   typedef struct packed {
      logic [3:0] frames;
      logic       clear;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic             hit;
      logic [2:0]       frame_index;
      logic             evicted_valid;
      logic [15:0]      evicted_page;
      logic [CNT_W-1:0] hit_total;
      logic [CNT_W-1:0] fault_total;
   } result_type;

endpackage

[hw/rtl/lrupr_ram.sv]
// generic single write port ram with a registered read port
module lrupr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lrupr_csr.sv]
// configuration register port holding frames_in_use
module lrupr_csr
   import lrupr_pkg::*;
#(
   parameter int FRAMES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   localparam logic [3:0] FramesReset = (FRAMES < 8) ? 4'(FRAMES) : 4'd8;

   logic [3:0] frames_ff;
   logic [3:0] frames_in;
   logic       wr_hit;

   // write strobe for the frames register
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_FRAMES_IN_USE);

   always_comb begin
      frames_in = frames_ff;
      if (wr_hit) begin
         frames_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FramesReset;
      end else begin
         frames_ff <= frames_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_FRAMES_IN_USE) begin
         csr_prdata = {{(CSR_DATA_W-4){1'b0}}, frames_ff};
      end
   end

   assign csr_pready   = 1'b1;
   assign cfg.frames   = frames_ff;
   assign cfg.clear    = wr_hit;

endmodule

[hw/rtl/lrupr_engine.sv]
// scan and update sequencer around the frame table ram
module lrupr_engine
   import lrupr_pkg::*;
#(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [REQ_DATA_W-1:0] in_page,
   output logic                  out_valid,
   input  logic                  out_ready,
   output result_type            out_res
);

   localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CW = $clog2(FRAMES + 1);
   localparam int RW = IW;
   localparam int EW = PAGE_BITS + RW;

   typedef enum logic [2:0] {
      IDLE, SCAN, SCAN_TAIL, DECIDE, UPDATE, UPDATE_TAIL, DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [IW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        found_idx_ff, found_idx_in;
   logic [RW-1:0]        found_rank_ff, found_rank_in;
   logic [CW-1:0]        vcount_ff, vcount_in;
   logic                 empty_ff, empty_in;
   logic [IW-1:0]        empty_idx_ff, empty_idx_in;
   logic [IW-1:0]        lru_idx_ff, lru_idx_in;
   logic [RW-1:0]        lru_rank_ff, lru_rank_in;
   logic [PAGE_BITS-1:0] lru_page_ff, lru_page_in;
   logic [IW-1:0]        tgt_ff, tgt_in;
   logic [CW-1:0]        thr_ff, thr_in;
   logic                 ev_valid_ff, ev_valid_in;
   logic [PAGE_BITS-1:0] ev_page_ff, ev_page_in;
   logic [FRAMES-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]     hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]     fault_cnt_ff, fault_cnt_in;
   result_type           res_ff, res_in;

   logic                 rd_en, wr_en;
   logic [IW-1:0]        rd_addr, wr_addr;
   logic [EW-1:0]        wr_data, rd_data;
   logic [PAGE_BITS-1:0] rd_page;
   logic [RW-1:0]        rd_rank;
   logic [5:0]           frames_ext;
   logic [CW-1:0]        used;
   logic                 last_issue;

   // frame table: page number and recency rank per frame
   lrupr_ram #(
      .WIDTH (EW),
      .DEPTH (FRAMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_page = rd_data[RW +: PAGE_BITS];
   assign rd_rank = rd_data[RW-1:0];

   // frames taking part, clamped to 1..FRAMES
   assign frames_ext = {2'b00, cfg.frames};
   always_comb begin
      if (frames_ext == 6'd0) begin
         used = CW'(1);
      end else if (frames_ext > 6'(FRAMES)) begin
         used = CW'(FRAMES);
      end else begin
         used = CW'(frames_ext);
      end
   end

   assign last_issue = (idx_ff == (used - CW'(1)));

   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      idx_in        = idx_ff;
      rd_pend_in    = rd_pend_ff;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_rank_in = found_rank_ff;
      vcount_in     = vcount_ff;
      empty_in      = empty_ff;
      empty_idx_in  = empty_idx_ff;
      lru_idx_in    = lru_idx_ff;
      lru_rank_in   = lru_rank_ff;
      lru_page_in   = lru_page_ff;
      tgt_in        = tgt_ff;
      thr_in        = thr_ff;
      ev_valid_in   = ev_valid_ff;
      ev_page_in    = ev_page_ff;
      valid_in      = valid_ff;
      hit_cnt_in    = hit_cnt_ff;
      fault_cnt_in  = fault_cnt_ff;
      res_in        = res_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[IW-1:0];
      wr_en         = 1'b0;
      wr_addr       = rd_idx_ff;
      wr_data       = {page_ff, {RW{1'b0}}};

      // sequencer
      unique case (state_ff) inside
         IDLE: begin
            if (in_valid) begin
               page_in    = PAGE_BITS'(in_page);
               idx_in     = '0;
               rd_pend_in = 1'b0;
               found_in   = 1'b0;
               vcount_in  = '0;
               empty_in   = 1'b0;
               state_in   = SCAN;
            end
         end
         SCAN, UPDATE: begin
            rd_en      = 1'b1;
            rd_pend_in = 1'b1;
            rd_idx_in  = idx_ff[IW-1:0];
            idx_in     = idx_ff + CW'(1);
            if (last_issue) begin
               state_in = (state_ff == SCAN) ? SCAN_TAIL : UPDATE_TAIL;
            end
         end
         SCAN_TAIL: begin
            rd_pend_in = 1'b0;
            state_in   = DECIDE;
         end
         DECIDE: begin
            ev_valid_in = 1'b0;
            ev_page_in  = '0;
            if (found_ff) begin
               tgt_in = found_idx_ff;
               thr_in = CW'(found_rank_ff);
            end else if (empty_ff) begin
               tgt_in = empty_idx_ff;
               thr_in = vcount_ff;
            end else begin
               tgt_in      = lru_idx_ff;
               thr_in      = CW'(lru_rank_ff);
               ev_valid_in = 1'b1;
               ev_page_in  = lru_page_ff;
            end
            idx_in   = '0;
            state_in = UPDATE;
         end
         UPDATE_TAIL: begin
            rd_pend_in       = 1'b0;
            valid_in[tgt_ff] = 1'b1;
            if (found_ff) begin
               if (hit_cnt_ff != COUNT_MAX) begin
                  hit_cnt_in = hit_cnt_ff + CNT_W'(1);
               end
            end else if (fault_cnt_ff != COUNT_MAX) begin
               fault_cnt_in = fault_cnt_ff + CNT_W'(1);
            end
            res_in.hit           = found_ff;
            res_in.frame_index   = 3'(tgt_ff);
            res_in.evicted_valid = ev_valid_ff;
            res_in.evicted_page  = 16'(ev_page_ff);
            res_in.hit_total     = hit_cnt_in;
            res_in.fault_total   = fault_cnt_in;
            state_in             = DONE;
         end
         DONE: begin
            if (out_ready) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      // lookup pass: fold one returned entry into the scan results
      if (rd_pend_ff && (state_ff == SCAN || state_ff == SCAN_TAIL)) begin
         if (valid_ff[rd_idx_ff]) begin
            vcount_in = vcount_ff + CW'(1);
            if (!found_ff && rd_page == page_ff) begin
               found_in      = 1'b1;
               found_idx_in  = rd_idx_ff;
               found_rank_in = rd_rank;
            end
            if (vcount_ff == '0 || rd_rank > lru_rank_ff) begin
               lru_idx_in  = rd_idx_ff;
               lru_rank_in = rd_rank;
               lru_page_in = rd_page;
            end
         end else if (!empty_ff) begin
            empty_in     = 1'b1;
            empty_idx_in = rd_idx_ff;
         end
      end

      // update pass: age younger frames, load the target frame
      if (rd_pend_ff && (state_ff == UPDATE || state_ff == UPDATE_TAIL)) begin
         if (rd_idx_ff == tgt_ff) begin
            wr_en   = 1'b1;
            wr_data = {page_ff, {RW{1'b0}}};
         end else if (valid_ff[rd_idx_ff] && (CW'(rd_rank) < thr_ff)) begin
            wr_en   = 1'b1;
            wr_data = {rd_page, rd_rank + RW'(1)};
         end
      end

      // register write empties the table and counters
      if (cfg.clear) begin
         valid_in     = '0;
         hit_cnt_in   = '0;
         fault_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rd_pend_ff   <= 1'b0;
         valid_ff     <= '0;
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         valid_ff     <= valid_in;
         hit_cnt_ff   <= hit_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
      end
      page_ff       <= page_in;
      idx_ff        <= idx_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_rank_ff <= found_rank_in;
      vcount_ff     <= vcount_in;
      empty_ff      <= empty_in;
      empty_idx_ff  <= empty_idx_in;
      lru_idx_ff    <= lru_idx_in;
      lru_rank_ff   <= lru_rank_in;
      lru_page_ff   <= lru_page_in;
      tgt_ff        <= tgt_in;
      thr_ff        <= thr_in;
      ev_valid_ff   <= ev_valid_in;
      ev_page_ff    <= ev_page_in;
      res_ff        <= res_in;
   end

   assign in_ready  = (state_ff == IDLE);
   assign out_valid = (state_ff == DONE);
   assign out_res   = res_ff;

endmodule

[hw/rtl/lru_page_replacement.sv]
// top level of the lru page replacement block
//
// Takes one page reference per item on the req_ channel and returns one
// result item per reference on the rsp_ channel: hit flag, frame hit or
// filled, evicted page if any, and the saturating hit and fault totals.
// The frame table (page number and recency rank per frame) lives in one
// ram with a registered read; valid bits and counters are flip-flops.
// Each reference takes a lookup pass and an update pass over the frames
// in use, one ram read per frame per pass.
// The rsp_ side has its own output register, so the next reference is
// taken and worked on while a result waits; with the receiver stalled the
// block holds its second result until the register drains.
// Reset empties all frames, clears both counters and sets frames_in_use
// to eight (or FRAMES if smaller). A write of frames_in_use over the csr_
// port empties the frames and clears the counters as well; write it only
// while no item is in flight.
module lru_page_replacement
   import lrupr_pkg::*;
#(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // page_number [15:0]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // frame_index [2:0], evicted_valid [3], evicted_page [19:4],
   // hit_total [51:20], fault_total [83:52], zero [87:84]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // hit [0]
   output logic                  rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   logic       eng_valid;
   logic       eng_ready;
   result_type eng_res;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_res_ff, rsp_res_in;

   // configuration register
   lrupr_csr #(
      .FRAMES (FRAMES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // lookup and replacement engine
   lrupr_engine #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_page   (req_tdata),
      .out_valid (eng_valid),
      .out_ready (eng_ready),
      .out_res   (eng_res)
   );

   // output register
   assign eng_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (eng_ready) begin
         rsp_valid_in = eng_valid;
         rsp_res_in   = eng_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.hit;
   assign rsp_tdata  = {4'b0000, rsp_res_ff.fault_total, rsp_res_ff.hit_total,
                        rsp_res_ff.evicted_page, rsp_res_ff.evicted_valid,
                        rsp_res_ff.frame_index};

endmodule
